FILE: sv/bar_synced_loop_recorder_assert.svh
// Assertion macros used by the checker file of the loop recorder.
`ifndef BAR_SYNCED_LOOP_RECORDER_ASSERT_SVH
`define BAR_SYNCED_LOOP_RECORDER_ASSERT_SVH

// Checked at every rising clock edge outside of reset.
`define BSLR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define BSLR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/bslr_pkg.sv
// Shared constants, codes and controller/datapath interface types of the loop recorder.
package bslr_pkg;

   localparam int MAX_LOOP = 131072;
   localparam int MIN_LOOP = 512;
   localparam int ADDR_W   = $clog2(MAX_LOOP);
   localparam int SIZE_W   = ADDR_W + 1;
   localparam int IN_DATA_W  = 128;
   localparam int OUT_DATA_W = 56;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_ARM  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_WAIT = 2'd1;
   localparam logic [1:0] MODE_ON   = 2'd2;

   localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
   localparam logic [2:0] REG_LATENCY    = 3'd1;
   localparam logic [2:0] REG_FADE       = 3'd2;
   localparam logic [2:0] REG_LOOP       = 3'd3;
   localparam logic [2:0] REG_BAR        = 3'd4;
   localparam logic [2:0] REG_BEAT       = 3'd5;

   typedef enum logic [4:0] {
      OP_IDLE, OP_LATCH, OP_DIV, OP_SQRT, OP_START_REC, OP_CLEAR, OP_TIMING,
      OP_ENV, OP_SCALE, OP_WRITE, OP_STOP, OP_ARM, OP_POS, OP_RDA, OP_RDB,
      OP_RDC, OP_INTERP, OP_BEATQ, OP_PHASE, OP_OUT
   } dp_op_type;

   typedef enum logic [2:0] {
      DIV_TBAR, DIV_QBAR, DIV_RBEAT, DIV_PHASE, DIV_FADE_D, DIV_FADE_R, DIV_POSL, DIV_POSR
   } div_sel_type;

   typedef struct packed {
      dp_op_type   op;
      div_sel_type div_sel;
      logic        right;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] mode;
      logic       div_busy;
      logic       sqrt_busy;
      logic       wait_hit;
      logic       write_ok;
      logic       fade_in;
      logic       in_loop;
      logic       fade_out;
      logic       clr_last;
      logic       q_in;
      logic       out_free;
   } dp_stat_type;

endpackage

FILE: sv/bslr_div.sv
// Restoring divider, one quotient bit per cycle.
module bslr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [23:0] divisor,
   output logic        busy,
   output logic [63:0] quot,
   output logic [23:0] rem
);
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quot_ff, quot_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [24:0] shifted;

   // The divisor is held for the whole run, since the select that feeds it moves on.
   always_comb begin
      shifted = {rem_ff[23:0], quot_ff[63]};
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = 7'd64;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in  = shifted - {1'b0, dvs_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign quot = quot_ff;
   assign rem  = rem_ff[23:0];
endmodule

FILE: sv/bslr_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module bslr_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        busy,
   output logic [15:0] root
);
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rad_ff, rad_in;
   logic [17:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [17:0] r;
   logic [17:0] trial;

   always_comb begin
      r       = {rem_ff[15:0], rad_ff[31:30]};
      trial   = {root_ff, 2'b01};
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         cnt_in  = 5'd16;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         rad_in = {rad_ff[29:0], 2'b00};
         if (r >= trial) begin
            rem_in  = r - trial;
            root_in = {root_ff[14:0], 1'b1};
         end else begin
            rem_in  = r;
            root_in = {root_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = (cnt_ff != 5'd0);
   assign root = root_ff;
endmodule

FILE: sv/bslr_ctrl.sv
// Sequencer of the loop recorder: steps the datapath through one item at a time.
module bslr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bslr_pkg::dp_stat_type stat,
   output bslr_pkg::ctrl_cmd_type cmd
);
   import bslr_pkg::*;

   typedef enum logic [4:0] {
      S_BOOT_CLR, S_IDLE, S_DISPATCH, S_DIVW, S_SQW, S_WCHK, S_RCLR, S_TIMING,
      S_TCHK, S_SQ1, S_ENV1, S_FOCHK, S_SQ2, S_ENV2, S_SCALE, S_WRITE,
      S_PDIV, S_POS, S_RDA, S_RDB, S_RDC, S_INTERP, S_BQ, S_BCHK, S_B2, S_B3,
      S_B4, S_OUT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      side_ff, side_in;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      side_in     = side_ff;
      cmd.op      = OP_IDLE;
      cmd.div_sel = DIV_TBAR;
      cmd.right   = side_ff;
      req_tready  = 1'b0;
      case (state_ff)
         S_BOOT_CLR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            side_in = 1'b0;
            case (stat.command)
               CMD_TICK: begin
                  if (stat.mode == MODE_WAIT) begin
                     cmd.op   = OP_DIV;
                     cmd.div_sel = DIV_TBAR;
                     ret_in   = S_WCHK;
                     state_in = S_DIVW;
                  end else begin
                     state_in = S_TIMING;
                  end
               end
               CMD_ARM: begin
                  cmd.op   = OP_ARM;
                  state_in = S_BQ;
               end
               CMD_READ: state_in = S_PDIV;
               default:  state_in = S_BQ;
            endcase
         end
         S_DIVW: if (!stat.div_busy) state_in = ret_ff;
         S_SQW:  if (!stat.sqrt_busy) state_in = ret_ff;
         S_WCHK: begin
            if (stat.wait_hit) begin
               cmd.op   = OP_START_REC;
               state_in = S_RCLR;
            end else begin
               state_in = S_BQ;
            end
         end
         S_RCLR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) state_in = S_TIMING;
         end
         S_TIMING: begin
            if (stat.mode == MODE_ON) begin
               cmd.op   = OP_TIMING;
               state_in = S_TCHK;
            end else begin
               state_in = S_BQ;
            end
         end
         S_TCHK: begin
            if (!stat.write_ok) begin
               state_in = S_BQ;
            end else if (stat.fade_in) begin
               cmd.op      = OP_DIV;
               cmd.div_sel = DIV_FADE_D;
               ret_in      = S_SQ1;
               state_in    = S_DIVW;
            end else begin
               state_in = S_FOCHK;
            end
         end
         S_SQ1: begin
            cmd.op   = OP_SQRT;
            ret_in   = S_ENV1;
            state_in = S_SQW;
         end
         S_ENV1: begin
            cmd.op   = OP_ENV;
            state_in = S_FOCHK;
         end
         S_FOCHK: begin
            if (!stat.in_loop) begin
               cmd.op   = OP_STOP;
               state_in = S_BQ;
            end else if (stat.fade_out) begin
               cmd.op      = OP_DIV;
               cmd.div_sel = DIV_FADE_R;
               ret_in      = S_SQ2;
               state_in    = S_DIVW;
            end else begin
               state_in = S_SCALE;
            end
         end
         S_SQ2: begin
            cmd.op   = OP_SQRT;
            ret_in   = S_ENV2;
            state_in = S_SQW;
         end
         S_ENV2: begin
            cmd.op   = OP_ENV;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = S_BQ;
         end
         S_PDIV: begin
            cmd.op      = OP_DIV;
            cmd.div_sel = side_ff ? DIV_POSR : DIV_POSL;
            ret_in      = S_POS;
            state_in    = S_DIVW;
         end
         S_POS: begin
            cmd.op   = OP_POS;
            state_in = S_RDA;
         end
         S_RDA: begin
            cmd.op   = OP_RDA;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op   = OP_RDB;
            state_in = S_RDC;
         end
         S_RDC: begin
            cmd.op   = OP_RDC;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            cmd.op = OP_INTERP;
            if (side_ff) begin
               state_in = S_BQ;
            end else begin
               side_in  = 1'b1;
               state_in = S_PDIV;
            end
         end
         S_BQ: begin
            cmd.op   = OP_BEATQ;
            state_in = S_BCHK;
         end
         S_BCHK: begin
            if (stat.q_in) begin
               cmd.op      = OP_DIV;
               cmd.div_sel = DIV_QBAR;
               ret_in      = S_B2;
               state_in    = S_DIVW;
            end else begin
               state_in = S_OUT;
            end
         end
         S_B2: begin
            cmd.op      = OP_DIV;
            cmd.div_sel = DIV_RBEAT;
            ret_in      = S_B3;
            state_in    = S_DIVW;
         end
         S_B3: begin
            cmd.op      = OP_DIV;
            cmd.div_sel = DIV_PHASE;
            ret_in      = S_B4;
            state_in    = S_DIVW;
         end
         S_B4: begin
            cmd.op   = OP_PHASE;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT_CLR;
         ret_ff   <= S_IDLE;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         side_ff  <= side_in;
      end
   end
endmodule

FILE: sv/bslr_dp.sv
// Datapath of the loop recorder: registers, loop memory, divider, square root and output stage.
module bslr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bslr_pkg::ctrl_cmd_type              cmd,
   output bslr_pkg::dp_stat_type               stat,
   input  logic [1:0]                          req_tuser,
   input  logic [bslr_pkg::IN_DATA_W-1:0]      req_tdata,
   input  logic                                csr_valid,
   input  logic [2:0]                          csr_index,
   input  logic [23:0]                         csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bslr_pkg::OUT_DATA_W-1:0]     rsp_tdata
);
   import bslr_pkg::*;

   logic [12:0] bs_ff;
   logic [15:0] lat_ff;
   logic [17:0] fade_ff;
   logic [17:0] loop_ff;
   logic [23:0] bar_ff, beat_ff;

   logic [1:0]  cmd_ff;
   logic [31:0] t_ff, posl_ff, posr_ff;
   logic signed [15:0] sl_ff, sr_ff;
   logic [1:0]  mode_ff;
   logic [31:0] start_ff;
   logic        ok_ff;
   logic [31:0] ptr_ff, d_ff, bq_ff;
   logic [SIZE_W-1:0] rest_ff;
   logic [16:0] env_ff;
   logic [15:0] prodl_ff, prodr_ff;
   logic [ADDR_W-1:0] clr_ff, p_ff, q_ff;
   logic [31:0] rd_ff;
   logic signed [15:0] a_ff, b_ff, vl_ff, vr_ff;
   logic [15:0] phase_ff;
   logic        bvalid_ff;
   logic        rsp_valid_ff;
   logic [OUT_DATA_W-1:0] rsp_data_ff;

   logic [31:0] mem [MAX_LOOP];

   logic [SIZE_W-1:0] size;
   logic [23:0] bar_eff, beat_eff;
   logic [63:0] div_dividend;
   logic [23:0] div_divisor;
   logic        div_busy, sqrt_busy;
   logic [63:0] div_quot;
   logic [23:0] div_rem;
   logic [15:0] sq_root;
   logic [31:0] elapsed;
   logic [31:0] ptr_new;
   logic [SIZE_W-1:0] p_next;
   logic signed [33:0] scl, scr;
   logic [32:0] env_prod;
   logic [8:0]  frac, wa;
   logic [7:0]  fbits;
   logic signed [26:0] interp;
   logic [15:0] half_rd;
   logic        we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [31:0] wdata;

   always_comb begin
      if (loop_ff < SIZE_W'(MIN_LOOP)) size = SIZE_W'(MIN_LOOP);
      else if (loop_ff > SIZE_W'(MAX_LOOP)) size = SIZE_W'(MAX_LOOP);
      else size = loop_ff;
      bar_eff  = (bar_ff == '0) ? 24'd1 : bar_ff;
      beat_eff = (beat_ff == '0) ? 24'd1 : beat_ff;
   end

   always_comb begin
      div_dividend = {32'd0, t_ff};
      div_divisor  = bar_eff;
      case (cmd.div_sel)
         DIV_TBAR:   div_dividend = {32'd0, t_ff};
         DIV_QBAR:   div_dividend = {32'd0, bq_ff};
         DIV_RBEAT: begin
            div_dividend = {40'd0, div_rem};
            div_divisor  = beat_eff;
         end
         DIV_PHASE: begin
            div_dividend = {24'd0, div_rem, 16'd0};
            div_divisor  = beat_eff;
         end
         DIV_FADE_D: begin
            div_dividend = {14'd0, d_ff[17:0], 32'd0};
            div_divisor  = {6'd0, fade_ff};
         end
         DIV_FADE_R: begin
            div_dividend = {14'd0, rest_ff[17:0], 32'd0};
            div_divisor  = {6'd0, fade_ff};
         end
         DIV_POSL: begin
            div_dividend = {40'd0, posl_ff[31:8]};
            div_divisor  = {6'd0, size};
         end
         DIV_POSR: begin
            div_dividend = {40'd0, posr_ff[31:8]};
            div_divisor  = {6'd0, size};
         end
         default: ;
      endcase
   end

   bslr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   bslr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_SQRT),
      .radicand (div_quot[31:0]),
      .busy     (sqrt_busy),
      .root     (sq_root)
   );

   always_comb begin
      elapsed  = t_ff - start_ff;
      ptr_new  = elapsed - {16'd0, lat_ff};
      p_next   = {1'b0, div_rem[ADDR_W-1:0]} + SIZE_W'(1);
      env_prod = env_ff * sq_root;
      scl      = sl_ff * $signed({1'b0, env_ff});
      scr      = sr_ff * $signed({1'b0, env_ff});
      half_rd  = cmd.right ? rd_ff[31:16] : rd_ff[15:0];
      fbits    = cmd.right ? posr_ff[7:0] : posl_ff[7:0];
      frac     = {1'b0, fbits};
      wa       = 9'd256 - frac;
      interp   = $signed({1'b0, wa}) * a_ff + $signed({1'b0, frac}) * b_ff;
   end

   // One write port shared by the clearing sweep and sample writes.
   always_comb begin
      we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
      waddr = (cmd.op == OP_CLEAR) ? clr_ff : ptr_ff[ADDR_W-1:0];
      wdata = (cmd.op == OP_CLEAR) ? 32'd0 : {prodr_ff, prodl_ff};
      raddr = (cmd.op == OP_RDB) ? q_ff : p_ff;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= 13'd512;
         lat_ff       <= 16'd0;
         fade_ff      <= 18'd256;
         loop_ff      <= 18'd512;
         bar_ff       <= 24'd88200;
         beat_ff      <= 24'd22050;
         mode_ff      <= MODE_OFF;
         start_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_BLOCK_SIZE: bs_ff   <= csr_data[12:0];
               REG_LATENCY:    lat_ff  <= csr_data[15:0];
               REG_FADE:       fade_ff <= csr_data[17:0];
               REG_LOOP:       loop_ff <= csr_data[17:0];
               REG_BAR:        bar_ff  <= csr_data;
               REG_BEAT:       beat_ff <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            OP_START_REC: begin
               mode_ff  <= MODE_ON;
               start_ff <= t_ff - {19'd0, bs_ff};
            end
            OP_CLEAR: clr_ff  <= clr_ff + ADDR_W'(1);
            OP_STOP:  mode_ff <= MODE_OFF;
            OP_ARM:   mode_ff <= MODE_WAIT;
            default: ;
         endcase
         if (cmd.op == OP_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            cmd_ff  <= req_tuser;
            t_ff    <= req_tdata[31:0];
            sl_ff   <= req_tdata[47:32];
            sr_ff   <= req_tdata[63:48];
            posl_ff <= req_tdata[95:64];
            posr_ff <= req_tdata[127:96];
            vl_ff   <= '0;
            vr_ff   <= '0;
         end
         OP_TIMING: begin
            ok_ff   <= {1'b0, elapsed} >= ({20'd0, bs_ff} + {17'd0, lat_ff});
            ptr_ff  <= ptr_new;
            d_ff    <= ptr_new - {19'd0, bs_ff};
            rest_ff <= size - ptr_new[SIZE_W-1:0];
            env_ff  <= 17'h10000;
         end
         OP_ENV: env_ff <= env_prod[32:16];
         OP_SCALE: begin
            prodl_ff <= scl[31:16];
            prodr_ff <= scr[31:16];
         end
         OP_POS: begin
            p_ff <= div_rem[ADDR_W-1:0];
            q_ff <= (p_next == size) ? '0 : p_next[ADDR_W-1:0];
         end
         OP_RDB: a_ff <= half_rd;
         OP_RDC: b_ff <= half_rd;
         OP_INTERP: begin
            if (cmd.right) vr_ff <= interp[23:8];
            else vl_ff <= interp[23:8];
         end
         OP_BEATQ: begin
            bq_ff     <= t_ff - start_ff - {19'd0, bs_ff};
            phase_ff  <= '0;
            bvalid_ff <= 1'b0;
         end
         OP_PHASE: begin
            phase_ff  <= div_quot[15:0];
            bvalid_ff <= 1'b1;
         end
         OP_OUT: rsp_data_ff <= {5'd0, bvalid_ff, phase_ff, mode_ff, vr_ff, vl_ff};
         default: ;
      endcase
   end

   always_comb begin
      stat.command   = cmd_ff;
      stat.mode      = mode_ff;
      stat.div_busy  = div_busy;
      stat.sqrt_busy = sqrt_busy;
      stat.wait_hit  = div_rem < {11'd0, bs_ff};
      stat.write_ok  = ok_ff;
      stat.fade_in   = d_ff < {14'd0, fade_ff};
      stat.in_loop   = ptr_ff < {14'd0, size};
      stat.fade_out  = rest_ff < fade_ff;
      stat.clr_last  = (clr_ff == ADDR_W'(MAX_LOOP - 1));
      stat.q_in      = bq_ff < {14'd0, size};
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

FILE: sv/bar_synced_loop_recorder.sv
// Each accepted item (arm, tick or read) yields one result; the beat phase adds work when it
// applies, each division holds the shared divider and each square root the root unit. A tick in
// waiting mode adds a bar check and, when it starts a recording, a clear of the loop memory.
// Items are taken one at a time: the input reopens in the same cycle the result is presented.
// Reset is synchronous; after it a clear of the loop memory runs before the first item is accepted.
module bar_synced_loop_recorder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: tick_time, sample_left, sample_right, read_pos_left, read_pos_right
   input  logic [bslr_pkg::IN_DATA_W-1:0]   req_tdata,
   // tuser: command
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: value_left, value_right, record_status, beat_phase, beat_valid, zero fill
   output logic [bslr_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [2:0]                       csr_index,
   input  logic [23:0]                      csr_data
);
   import bslr_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   bslr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bslr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

FILE: sv/bslr_check.sv
// Port-level checker of the loop recorder and its bind to the top level.
`include "bar_synced_loop_recorder_assert.svh"
module bslr_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bslr_pkg::OUT_DATA_W-1:0]  rsp_tdata
);
   // A result held back by the sink must not change.
   `BSLR_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "result changed while stalled")
   // Items are worked one at a time, so an accepted item closes the input for a while.
   `BSLR_ASSERT(a_one_item, req_tvalid && req_tready |=> !req_tready, "second item accepted at once")
   // The memory clear after reset keeps the input closed and no result pending.
   `BSLR_ASSERT_ALWAYS(a_boot, $fell(reset) |-> !req_tready && !rsp_tvalid, "block open right after reset")
   // A beat phase is only reported inside the recorded loop.
   `BSLR_ASSERT(a_phase, rsp_tvalid && !rsp_tdata[50] |-> rsp_tdata[49:34] == 16'd0, "phase outside loop")
endmodule

bind bar_synced_loop_recorder bslr_check u_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
